FILE: hdl/lfu_pkg.sv
// ============================================================================
// lfu_pkg - shared types and constants for the LFU cache table
// Holds the entry layout, the request codes, the controller states and the
// command and status bundles that pass between the controller and datapath.
// ============================================================================
package lfu_pkg;

    // Field widths of one request and one table entry.
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 32;
    localparam int STAMP_W = 64;
    localparam int CFG_W   = 5;

    // Default table depth and reset value of the capacity register.
    localparam int                CAPACITY_DEF = 16;
    localparam logic [CFG_W-1:0]  CFG_RESET    = 5'd16;

    // Request codes.
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // One stored entry, as kept in the table memory.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_UPDATE
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic start;   // latch a request beat and begin a new search
        logic scan;    // read the next table entry
        logic commit;  // write back the chosen entry and load the result
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic last_addr;  // the scan address points at the last entry
        logic out_busy;   // the result register holds a beat not yet taken
    } t_sts;

endpackage

FILE: hdl/lfu_if.sv
// ============================================================================
// lfu_if - request and response channel interfaces
// Valid/ready channels; a beat moves on a clock edge with valid and ready high.
// ============================================================================

// Request channel: one get or put per beat.
interface lfu_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [lfu_pkg::KEY_W-1:0]    key;
    logic [lfu_pkg::VALUE_W-1:0]  value;

    modport source (output valid, func, key, value, input ready);
    modport sink   (input valid, func, key, value, output ready);
endinterface

// Response channel: one result per request.
interface lfu_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [lfu_pkg::VALUE_W-1:0]  read_value;

    modport source (output valid, hit, read_value, input ready);
    modport sink   (input valid, hit, read_value, output ready);
endinterface

FILE: hdl/lfu_ram.sv
// ============================================================================
// lfu_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/lfu_ctrl.sv
// ============================================================================
// lfu_ctrl - request sequencer for the LFU cache table
// Accepts a request, walks the datapath through the table scan, then commits
// the update once the result register is free.
// ============================================================================
module lfu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  lfu_pkg::t_sts i_sts,
    output lfu_pkg::t_cmd o_cmd
);

    lfu_pkg::t_state r_state;
    lfu_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state      = r_state;
        o_req_ready  = 1'b0;
        o_cmd        = '0;
        case (r_state)
            lfu_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = lfu_pkg::S_SCAN;
                end
            end
            lfu_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.last_addr) begin
                    n_state = lfu_pkg::S_DRAIN;
                end
            end
            lfu_pkg::S_DRAIN: begin
                // The last entry read is evaluated in this cycle.
                n_state = lfu_pkg::S_UPDATE;
            end
            lfu_pkg::S_UPDATE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = lfu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lfu_pkg::S_IDLE;
            end
        endcase
    end

    // A scan that reaches the last address always drains next.
    a_scan_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lfu_pkg::S_SCAN && i_sts.last_addr) |=> (r_state == lfu_pkg::S_DRAIN))
        else $error("scan did not end in drain");

    // No commit while a result beat is still held back.
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !i_sts.out_busy)
        else $error("commit while result register busy");

endmodule

FILE: hdl/lfu_dp.sv
// ============================================================================
// lfu_dp - datapath of the LFU cache table
// Table memory, valid bits, the running key-match and victim search, the
// global stamp, the capacity register and the result register.
// ============================================================================
module lfu_dp #(
    parameter int CAPACITY = lfu_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lfu_pkg::t_cmd                i_cmd,
    output lfu_pkg::t_sts                o_sts,
    input  logic                         i_req_func,
    input  logic [lfu_pkg::KEY_W-1:0]    i_req_key,
    input  logic [lfu_pkg::VALUE_W-1:0]  i_req_value,
    input  logic                         i_cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                         o_rsp_valid,
    input  logic                         i_rsp_ready,
    output logic                         o_rsp_hit,
    output logic [lfu_pkg::VALUE_W-1:0]  o_rsp_read_value
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > lfu_pkg::CFG_W) ? CW : lfu_pkg::CFG_W;
    localparam int ENTRY_W = $bits(lfu_pkg::t_entry);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam logic [EW-1:0] CAP_E    = EW'(CAPACITY);

    // Control registers.
    logic [lfu_pkg::CFG_W-1:0]   r_cfg;
    logic [lfu_pkg::STAMP_W-1:0] r_stamp;
    logic [CAPACITY-1:0]         r_valid;
    logic                        r_ev_vld;
    logic                        r_out_valid;
    logic                        r_found;
    logic                        r_have_victim;
    logic                        r_have_free;
    logic [CW-1:0]               r_used;
    logic [IW-1:0]               r_idx;

    // Payload registers.
    logic                          r_func;
    logic [lfu_pkg::KEY_W-1:0]     r_key;
    logic [lfu_pkg::VALUE_W-1:0]   r_value;
    logic [IW-1:0]                 r_ev_idx;
    logic [IW-1:0]                 r_match_idx;
    logic [lfu_pkg::VALUE_W-1:0]   r_match_val;
    logic [lfu_pkg::COUNT_W-1:0]   r_match_cnt;
    logic [IW-1:0]                 r_victim_idx;
    logic [lfu_pkg::COUNT_W-1:0]   r_victim_cnt;
    logic [lfu_pkg::STAMP_W-1:0]   r_victim_stamp;
    logic [IW-1:0]                 r_free_idx;
    logic                          r_out_hit;
    logic [lfu_pkg::VALUE_W-1:0]   r_out_val;

    logic [ENTRY_W-1:0]  w_rdata;
    lfu_pkg::t_entry     w_rd;
    lfu_pkg::t_entry     w_new;
    logic                w_rd_valid;
    logic                w_match;
    logic                w_better;
    logic [EW-1:0]       w_cfg_e;
    logic [EW-1:0]       w_eff;
    logic                w_full;
    logic [IW-1:0]       w_slot;
    logic                w_we;

    // Table memory: one read per scan cycle, at most one write per commit.
    lfu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot),
        .i_wdata (w_new),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // Evaluation of the entry read in the previous cycle.
    assign w_rd       = lfu_pkg::t_entry'(w_rdata);
    assign w_rd_valid = r_ev_vld && r_valid[r_ev_idx];
    assign w_match    = w_rd_valid && (w_rd.key == r_key) && !r_found;
    assign w_better   = !r_have_victim || (w_rd.count < r_victim_cnt) ||
                        ((w_rd.count == r_victim_cnt) && (w_rd.stamp < r_victim_stamp));

    // Effective capacity: zero acts as one, larger than the table acts as full depth.
    assign w_cfg_e = EW'(r_cfg);
    always_comb begin
        if (r_cfg == '0) begin
            w_eff = EW'(1);
        end else if (w_cfg_e > CAP_E) begin
            w_eff = CAP_E;
        end else begin
            w_eff = w_cfg_e;
        end
    end
    assign w_full = EW'(r_used) >= w_eff;

    // Slot choice: the match, else the victim when full, else a free slot, else the victim.
    always_comb begin
        if (r_found) begin
            w_slot = r_match_idx;
        end else if (w_full && r_have_victim) begin
            w_slot = r_victim_idx;
        end else if (r_have_free) begin
            w_slot = r_free_idx;
        end else begin
            w_slot = r_victim_idx;
        end
    end

    // Entry written back: hits bump the saturating count, new keys start at one.
    always_comb begin
        w_new.key   = r_key;
        w_new.stamp = r_stamp;
        if (r_found && (r_func == lfu_pkg::FUNC_GET)) begin
            w_new.value = r_match_val;
        end else begin
            w_new.value = r_value;
        end
        if (!r_found) begin
            w_new.count = lfu_pkg::COUNT_W'(1);
        end else if (r_match_cnt == '1) begin
            w_new.count = r_match_cnt;
        end else begin
            w_new.count = r_match_cnt + lfu_pkg::COUNT_W'(1);
        end
    end

    // A get that misses leaves the table untouched.
    assign w_we = i_cmd.commit && (r_found || (r_func == lfu_pkg::FUNC_PUT));

    // Control state: capacity, stamp, valid bits, search flags, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg         <= lfu_pkg::CFG_RESET;
            r_stamp       <= '0;
            r_valid       <= '0;
            r_ev_vld      <= 1'b0;
            r_out_valid   <= 1'b0;
            r_found       <= 1'b0;
            r_have_victim <= 1'b0;
            r_have_free   <= 1'b0;
            r_used        <= '0;
            r_idx         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            r_ev_vld <= i_cmd.scan;
            if (i_cmd.start) begin
                r_stamp       <= r_stamp + lfu_pkg::STAMP_W'(1);
                r_found       <= 1'b0;
                r_have_victim <= 1'b0;
                r_have_free   <= 1'b0;
                r_used        <= '0;
                r_idx         <= '0;
            end else begin
                if (i_cmd.scan) begin
                    r_idx <= r_idx + IW'(1);
                end
                if (w_match) begin
                    r_found <= 1'b1;
                end
                if (w_rd_valid) begin
                    r_used <= r_used + CW'(1);
                    if (w_better) begin
                        r_have_victim <= 1'b1;
                    end
                end else if (r_ev_vld && !r_have_free) begin
                    r_have_free <= 1'b1;
                end
            end
            if (w_we) begin
                r_valid[w_slot] <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request latch, search candidates and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func  <= i_req_func;
            r_key   <= i_req_key;
            r_value <= i_req_value;
        end
        r_ev_idx <= r_idx;
        if (w_match) begin
            r_match_idx <= r_ev_idx;
            r_match_val <= w_rd.value;
            r_match_cnt <= w_rd.count;
        end
        if (w_rd_valid && w_better) begin
            r_victim_idx   <= r_ev_idx;
            r_victim_cnt   <= w_rd.count;
            r_victim_stamp <= w_rd.stamp;
        end
        if (r_ev_vld && !r_valid[r_ev_idx] && !r_have_free) begin
            r_free_idx <= r_ev_idx;
        end
        if (i_cmd.commit) begin
            r_out_hit <= r_found;
            if (r_found && (r_func == lfu_pkg::FUNC_GET)) begin
                r_out_val <= r_match_val;
            end else begin
                r_out_val <= '0;
            end
        end
    end

    // Status and result outputs.
    assign o_sts.last_addr = (r_idx == LAST_IDX);
    assign o_sts.out_busy  = r_out_valid && !i_rsp_ready;
    assign o_rsp_valid      = r_out_valid;
    assign o_rsp_hit        = r_out_hit;
    assign o_rsp_read_value = r_out_val;

    // Every commit presents a result beat in the next cycle.
    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("commit without result beat");

    // A new search starts with empty match and occupancy state.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> (!r_found && (r_used == '0) && (r_idx == '0)))
        else $error("search state not cleared on start");

    // The slot written by a commit is valid afterwards.
    a_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> r_valid[$past(w_slot)])
        else $error("written slot not marked valid");

endmodule

FILE: hdl/lfu_cache_table.sv
// ============================================================================
// lfu_cache_table - least-frequently-used cache table
// Fixed-capacity key/value table with LFU replacement; ties go to the oldest
// stamp, then to the lowest slot.
// ============================================================================
//
//  Port        Direction  Beat contents
//  ----------  ---------  ------------------------------------------------
//  i_req       sink       func (0 get, 1 put), key, value
//  o_rsp       source     hit, read_value (value on a get hit, else 0)
//  i_cfg_*     write      capacity_in_use (5 bits), no read-back
//
//  A request scans every entry: the table memory has one read port and the
//  scan reads one entry per cycle, then the last entry is evaluated and the
//  chosen entry is written back. The request side is ready only between
//  requests. The result sits in an output register; a stalled result delays
//  only the write-back of the following request.
//  Reset clears all valid bits at once, the stamp to zero and capacity to 16.
//
module lfu_cache_table #(
    parameter int CAPACITY = lfu_pkg::CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    lfu_req_if.sink                    i_req,
    lfu_rsp_if.source                  o_rsp,
    input  logic                       i_cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]  i_cfg_data
);

    lfu_pkg::t_cmd w_cmd;
    lfu_pkg::t_sts w_sts;

    // Sequencer.
    lfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Table, search and result datapath.
    lfu_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_req_func       (i_req.func),
        .i_req_key        (i_req.key),
        .i_req_value      (i_req.value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .o_rsp_valid      (o_rsp.valid),
        .i_rsp_ready      (o_rsp.ready),
        .o_rsp_hit        (o_rsp.hit),
        .o_rsp_read_value (o_rsp.read_value)
    );

endmodule
